// ===== hw/rtl/pqf_pkg.sv =====
`timescale 1ns / 1ps

package pqf_pkg;

  localparam int unsigned BATCH_LIMIT = 65535;
  localparam int TOTAL_W = $clog2(BATCH_LIMIT + 1);
  localparam int COUNT_W = 16;
  localparam int unsigned COUNT_MAX = 65535;
  localparam int WORD_W = 32;
  localparam int MODE_W = 3;
  localparam int ACTION_W = 2;
  localparam int SLOT_N = 4;
  localparam int SLOT_W = 2;
  localparam int STEP_W = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic [MODE_W-1:0] MODE_POINTS = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TRIS   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_FAN    = 3'd6;
  localparam logic [MODE_W-1:0] MODE_QUADS  = 3'd7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_VERTEX = 2'd0,
    ACT_BEGIN  = 2'd1,
    ACT_END    = 2'd2
  } action_e;

  // Work orders handed from the front to the back.
  typedef enum logic [2:0] {
    OP_HOLD = 3'd0,
    OP_PASS = 3'd1,
    OP_TRI  = 3'd2,
    OP_QUAD = 3'd3,
    OP_FAN  = 3'd4,
    OP_END  = 3'd5
  } op_e;

  typedef struct packed {
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
    logic [WORD_W-1:0] r;
    logic [WORD_W-1:0] g;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] a;
  } vertex_t;

  typedef struct packed {
    op_e                op;
    logic [SLOT_W-1:0]  slot;
    vertex_t            vtx;
    logic [SLOT_W-1:0]  nflush;
    logic [MODE_W-1:0]  raster_mode;
    logic [COUNT_W-1:0] batch_count;
  } entry_t;

endpackage

// ===== hw/rtl/primitive_assembler_quad_fan.sv =====
`timescale 1ns / 1ps

// Primitive assembler that turns quads and fans into triangle lists. A request
// is taken in every cycle while the four-entry work queue has room; requests
// that only hold a vertex produce no result, and the output port sends one
// result per cycle while it is not stalled: a quad gives six results per four
// vertices, a triangle three per three, a fan vertex three, a plain vertex one,
// and an end request one per flushed vertex plus one for the marker. The first
// result of a request passes through the work queue, the current-request
// registers and the output registers.
module primitive_assembler_quad_fan import pqf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [MODE_W-1:0]   prim_mode_i,
  input  logic [WORD_W-1:0]   pos_x_i,
  input  logic [WORD_W-1:0]   pos_y_i,
  input  logic [WORD_W-1:0]   pos_z_i,
  input  logic [WORD_W-1:0]   red_i,
  input  logic [WORD_W-1:0]   green_i,
  input  logic [WORD_W-1:0]   blue_i,
  input  logic [WORD_W-1:0]   alpha_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                kind_o,
  output logic [WORD_W-1:0]   out_x_o,
  output logic [WORD_W-1:0]   out_y_o,
  output logic [WORD_W-1:0]   out_z_o,
  output logic [WORD_W-1:0]   out_red_o,
  output logic [WORD_W-1:0]   out_green_o,
  output logic [WORD_W-1:0]   out_blue_o,
  output logic [WORD_W-1:0]   out_alpha_o,
  output logic [MODE_W-1:0]   raster_mode_o,
  output logic [COUNT_W-1:0]  batch_count_o,
  output logic                last_o
);

  logic    accept, push, pop, q_valid, q_full;
  entry_t  push_entry, head;
  vertex_t in_vtx, out_vtx;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vtx.x = pos_x_i;
    in_vtx.y = pos_y_i;
    in_vtx.z = pos_z_i;
    in_vtx.r = red_i;
    in_vtx.g = green_i;
    in_vtx.b = blue_i;
    in_vtx.a = alpha_i;
  end

  pqf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .action_i    (action_i),
    .prim_mode_i (prim_mode_i),
    .vtx_i       (in_vtx),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  pqf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head),
    .full_o  (q_full)
  );

  pqf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .vtx_o         (out_vtx),
    .raster_mode_o (raster_mode_o),
    .batch_count_o (batch_count_o),
    .last_o        (last_o)
  );

  assign out_x_o     = out_vtx.x;
  assign out_y_o     = out_vtx.y;
  assign out_z_o     = out_vtx.z;
  assign out_red_o   = out_vtx.r;
  assign out_green_o = out_vtx.g;
  assign out_blue_o  = out_vtx.b;
  assign out_alpha_o = out_vtx.a;

  // A marker always closes the results of its end request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> last_o)
    else $error("end marker without last");

  // Vertex results never carry marker fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !kind_o |-> raster_mode_o == '0 && batch_count_o == '0)
    else $error("vertex result carries marker fields");

  // The queue is only popped while it holds something.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("work queue popped while empty");

endmodule

// ===== hw/rtl/pqf_front.sv =====
`timescale 1ns / 1ps

module pqf_front import pqf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [MODE_W-1:0]   prim_mode_i,
  input  vertex_t             vtx_i,
  output logic                push_o,
  output entry_t              entry_o
);

  logic [MODE_W-1:0]  mode_q, mode_d;
  logic [SLOT_W-1:0]  pcount_q, pcount_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [TOTAL_W-1:0] total_end;

  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] t,
                                                 input logic [2:0] n);
    logic [TOTAL_W:0] sum;
    sum = {1'b0, t} + (TOTAL_W + 1)'(n);
    if (sum >= (TOTAL_W + 1)'(BATCH_LIMIT)) begin
      return TOTAL_W'(BATCH_LIMIT);
    end
    return sum[TOTAL_W-1:0];
  endfunction

  localparam int EXT_W = (TOTAL_W > COUNT_W) ? TOTAL_W : COUNT_W;

  function automatic logic [COUNT_W-1:0] clamp_count(input logic [TOTAL_W-1:0] t);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(t);
    if (ext > EXT_W'(COUNT_MAX)) begin
      return COUNT_W'(COUNT_MAX);
    end
    return ext[COUNT_W-1:0];
  endfunction

  assign total_end = sat_add(total_q, {1'b0, pcount_q});

  always_comb begin
    mode_d                = mode_q;
    pcount_d              = pcount_q;
    total_d               = total_q;
    push_o                = 1'b0;
    entry_o.op            = OP_PASS;
    entry_o.slot          = pcount_q;
    entry_o.vtx           = vtx_i;
    entry_o.nflush        = pcount_q;
    entry_o.raster_mode   = '0;
    entry_o.batch_count   = '0;
    if (accept_i) begin
      case (action_i)
        ACT_BEGIN: begin
          mode_d   = prim_mode_i;
          pcount_d = '0;
        end
        ACT_END: begin
          push_o              = 1'b1;
          entry_o.op          = OP_END;
          entry_o.batch_count = clamp_count(total_end);
          entry_o.raster_mode = (mode_q inside {MODE_QUADS, MODE_FAN}) ? MODE_TRIS : mode_q;
          mode_d   = MODE_POINTS;
          pcount_d = '0;
          total_d  = '0;
        end
        ACT_VERTEX: begin
          push_o = 1'b1;
          case (mode_q)
            MODE_QUADS: begin
              if (pcount_q == 2'd3) begin
                entry_o.op = OP_QUAD;
                pcount_d   = '0;
                total_d    = sat_add(total_q, 3'd6);
              end else begin
                entry_o.op = OP_HOLD;
                pcount_d   = pcount_q + 2'd1;
              end
            end
            MODE_TRIS: begin
              if (pcount_q == 2'd2) begin
                entry_o.op = OP_TRI;
                pcount_d   = '0;
                total_d    = sat_add(total_q, 3'd3);
              end else begin
                entry_o.op = OP_HOLD;
                pcount_d   = pcount_q + 2'd1;
              end
            end
            MODE_FAN: begin
              // The hub and the first rim vertex are held; every later
              // vertex closes a triangle and replaces the previous one.
              if (pcount_q inside {2'd0, 2'd1}) begin
                entry_o.op = OP_HOLD;
                pcount_d   = pcount_q + 2'd1;
              end else begin
                entry_o.op = OP_FAN;
                total_d    = sat_add(total_q, 3'd3);
              end
            end
            default: begin
              entry_o.op = OP_PASS;
              total_d    = sat_add(total_q, 3'd1);
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_POINTS;
      pcount_q <= '0;
      total_q  <= '0;
    end else begin
      mode_q   <= mode_d;
      pcount_q <= pcount_d;
      total_q  <= total_d;
    end
  end

endmodule

// ===== hw/rtl/pqf_queue.sv =====
`timescale 1ns / 1ps

module pqf_queue import pqf_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t head_o,
  output logic   full_o
);

  entry_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]     count_q, count_d;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (QPTR_W + 1)'(push_i) - (QPTR_W + 1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== hw/rtl/pqf_back.sv =====
`timescale 1ns / 1ps

module pqf_back import pqf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  entry_t              head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                kind_o,
  output vertex_t             vtx_o,
  output logic [MODE_W-1:0]   raster_mode_o,
  output logic [COUNT_W-1:0]  batch_count_o,
  output logic                last_o
);

  vertex_t             slot_q [SLOT_N];
  logic                cur_v_q, cur_v_d;
  op_e                 cur_op_q;
  vertex_t             cur_vtx_q [SLOT_N];
  logic [STEP_W-1:0]   cur_step_q, cur_step_d;
  logic [STEP_W-1:0]   cur_end_q;
  logic [SLOT_W-1:0]   cur_nflush_q;
  logic [MODE_W-1:0]   cur_mode_q;
  logic [COUNT_W-1:0]  cur_count_q;

  logic                ov_q;
  logic                kind_q;
  vertex_t             vtx_q;
  logic [MODE_W-1:0]   mode_q;
  logic [COUNT_W-1:0]  count_q;
  logic                last_q;

  logic                out_free, emit, finishing, head_hold, load, is_marker;
  logic [SLOT_W-1:0]   src;

  function automatic logic [STEP_W-1:0] last_step(input op_e op,
                                                  input logic [SLOT_W-1:0] nflush);
    case (op)
      OP_TRI:  return 3'd2;
      OP_QUAD: return 3'd5;
      OP_FAN:  return 3'd2;
      OP_END:  return STEP_W'(nflush);
      default: return 3'd0;
    endcase
  endfunction

  // Which captured vertex feeds a step; index 3 holds the vertex of the request.
  function automatic logic [SLOT_W-1:0] step_src(input op_e op,
                                                 input logic [STEP_W-1:0] step);
    case (op)
      OP_QUAD: begin
        case (step)
          3'd0:    return 2'd0;
          3'd1:    return 2'd1;
          3'd2:    return 2'd2;
          3'd3:    return 2'd0;
          3'd4:    return 2'd2;
          default: return 2'd3;
        endcase
      end
      OP_TRI, OP_FAN: begin
        case (step)
          3'd0:    return 2'd0;
          3'd1:    return 2'd1;
          default: return 2'd3;
        endcase
      end
      OP_END:  return step[SLOT_W-1:0];
      default: return 2'd3;
    endcase
  endfunction

  assign out_free  = !ov_q || !out_stall_i;
  assign emit      = cur_v_q && out_free;
  assign finishing = emit && (cur_step_q == cur_end_q);
  assign head_hold = q_valid_i && (head_i.op == OP_HOLD);
  // A held vertex only touches the pending store, which the running request
  // no longer needs since it captured its vertices when it was loaded.
  assign pop_o     = q_valid_i && (head_hold || !cur_v_q || finishing);
  assign load      = pop_o && !head_hold;
  assign is_marker = (cur_op_q == OP_END) && (cur_step_q == STEP_W'(cur_nflush_q));
  assign src       = step_src(cur_op_q, cur_step_q);

  always_comb begin
    cur_v_d    = cur_v_q;
    cur_step_d = cur_step_q;
    if (load) begin
      cur_v_d    = 1'b1;
      cur_step_d = '0;
    end else if (finishing) begin
      cur_v_d = 1'b0;
    end else if (emit) begin
      cur_step_d = cur_step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.op == OP_HOLD) begin
      slot_q[head_i.slot] <= head_i.vtx;
    end
    if (pop_o && head_i.op == OP_FAN) begin
      slot_q[1] <= head_i.vtx;
    end
    if (load) begin
      cur_op_q     <= head_i.op;
      cur_vtx_q[0] <= slot_q[0];
      cur_vtx_q[1] <= slot_q[1];
      cur_vtx_q[2] <= slot_q[2];
      cur_vtx_q[3] <= head_i.vtx;
      cur_end_q    <= last_step(head_i.op, head_i.nflush);
      cur_nflush_q <= head_i.nflush;
      cur_mode_q   <= head_i.raster_mode;
      cur_count_q  <= head_i.batch_count;
    end
    if (emit) begin
      kind_q  <= is_marker;
      vtx_q   <= is_marker ? '0 : cur_vtx_q[src];
      mode_q  <= is_marker ? cur_mode_q : '0;
      count_q <= is_marker ? cur_count_q : '0;
      last_q  <= (cur_step_q == cur_end_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q    <= 1'b0;
      cur_step_q <= '0;
      ov_q       <= 1'b0;
    end else begin
      cur_v_q    <= cur_v_d;
      cur_step_q <= cur_step_d;
      if (out_free) begin
        ov_q <= cur_v_q;
      end
    end
  end

  assign out_valid_o   = ov_q;
  assign kind_o        = kind_q;
  assign vtx_o         = vtx_q;
  assign raster_mode_o = mode_q;
  assign batch_count_o = count_q;
  assign last_o        = last_q;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import pqf_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED   = 2'd3;
  localparam logic [MODE_W-1:0]   MODE_LINES    = 3'd1;
  localparam logic [MODE_W-1:0]   MODE_LOOP     = 3'd2;
  localparam logic [MODE_W-1:0]   MODE_STRIP    = 3'd3;
  localparam logic [MODE_W-1:0]   MODE_TRISTRIP = 3'd5;
  localparam int unsigned RUN_LIMIT = 1000000;

  typedef struct packed {
    logic               kind;
    vertex_t            vtx;
    logic [MODE_W-1:0]  raster_mode;
    logic [COUNT_W-1:0] batch_count;
    logic               last;
  } assembled_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [ACTION_W-1:0] action_i;
  logic [MODE_W-1:0]   prim_mode_i;
  logic [WORD_W-1:0]   pos_x_i;
  logic [WORD_W-1:0]   pos_y_i;
  logic [WORD_W-1:0]   pos_z_i;
  logic [WORD_W-1:0]   red_i;
  logic [WORD_W-1:0]   green_i;
  logic [WORD_W-1:0]   blue_i;
  logic [WORD_W-1:0]   alpha_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                kind_o;
  logic [WORD_W-1:0]   out_x_o;
  logic [WORD_W-1:0]   out_y_o;
  logic [WORD_W-1:0]   out_z_o;
  logic [WORD_W-1:0]   out_red_o;
  logic [WORD_W-1:0]   out_green_o;
  logic [WORD_W-1:0]   out_blue_o;
  logic [WORD_W-1:0]   out_alpha_o;
  logic [MODE_W-1:0]   raster_mode_o;
  logic [COUNT_W-1:0]  batch_count_o;
  logic                last_o;

  // Predictor state of the assembler.
  logic [MODE_W-1:0] asm_mode = MODE_POINTS;
  int unsigned       held_count = 0;
  vertex_t           held_vtx [SLOT_N];
  int unsigned       emitted_total = 0;

  assembled_t  expected_results [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int          send_idle_pct = 29;
  int          recv_stall_pct = 74;

  primitive_assembler_quad_fan DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] got,
                             input logic [WORD_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(7))
      0: random_word = '0;
      1: random_word = '1;
      default: random_word = $urandom;
    endcase
  endfunction

  function automatic vertex_t random_vertex();
    random_vertex = '{x: random_word(), y: random_word(), z: random_word(),
                      r: random_word(), g: random_word(), b: random_word(),
                      a: random_word()};
  endfunction

  function automatic void emit_vertex(input vertex_t v);
    assembled_t res;
    res = '0;
    res.vtx = v;
    expected_results.push_back(res);
    if (emitted_total < BATCH_LIMIT) emitted_total++;
  endfunction

  function automatic void assemble_request(input logic [ACTION_W-1:0] act,
                                           input logic [MODE_W-1:0] mode, input vertex_t v);
    int unsigned start_size;
    assembled_t  marker;
    start_size = expected_results.size();
    case (act)
      ACT_BEGIN: begin
        asm_mode = mode;
        held_count = 0;
      end
      ACT_END: begin
        for (int i = 0; i < held_count; i++) emit_vertex(held_vtx[i]);
        marker = '0;
        marker.kind = 1'b1;
        marker.raster_mode = (asm_mode == MODE_QUADS || asm_mode == MODE_FAN) ? MODE_TRIS
                                                                              : asm_mode;
        marker.batch_count = COUNT_W'((emitted_total > COUNT_MAX) ? COUNT_MAX : emitted_total);
        expected_results.push_back(marker);
        held_count = 0;
        emitted_total = 0;
        asm_mode = MODE_POINTS;
      end
      ACT_VERTEX: begin
        case (asm_mode)
          MODE_QUADS: begin
            held_vtx[held_count] = v;
            held_count++;
            if (held_count == 4) begin
              emit_vertex(held_vtx[0]);
              emit_vertex(held_vtx[1]);
              emit_vertex(held_vtx[2]);
              emit_vertex(held_vtx[0]);
              emit_vertex(held_vtx[2]);
              emit_vertex(held_vtx[3]);
              held_count = 0;
            end
          end
          MODE_TRIS: begin
            held_vtx[held_count] = v;
            held_count++;
            if (held_count == 3) begin
              emit_vertex(held_vtx[0]);
              emit_vertex(held_vtx[1]);
              emit_vertex(held_vtx[2]);
              held_count = 0;
            end
          end
          MODE_FAN: begin
            // The hub stays in slot 0; slot 1 always holds the newest rim vertex.
            if (held_count < 2) begin
              held_vtx[held_count] = v;
              held_count++;
            end else begin
              emit_vertex(held_vtx[0]);
              emit_vertex(held_vtx[1]);
              emit_vertex(v);
              held_vtx[1] = v;
            end
          end
          default: emit_vertex(v);
        endcase
      end
      default: ;
    endcase
    if (expected_results.size() > start_size)
      expected_results[expected_results.size() - 1].last = 1'b1;
  endfunction

  // Called at a rising edge; returns at the edge where the request was taken.
  task automatic send_request(input logic [ACTION_W-1:0] act, input logic [MODE_W-1:0] mode,
                              input vertex_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    prim_mode_i <= mode;
    pos_x_i     <= v.x;
    pos_y_i     <= v.y;
    pos_z_i     <= v.z;
    red_i       <= v.r;
    green_i     <= v.g;
    blue_i      <= v.b;
    alpha_i     <= v.a;
    do @(posedge clk_i); while (in_stall_o);
    assemble_request(act, mode, v);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  always @(posedge clk_i) begin : check_results
    assembled_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result, kind %0d", kind_o));
      end else begin
        want = expected_results.pop_front();
        check_field("kind", WORD_W'(kind_o), WORD_W'(want.kind));
        check_field("out_x", out_x_o, want.vtx.x);
        check_field("out_y", out_y_o, want.vtx.y);
        check_field("out_z", out_z_o, want.vtx.z);
        check_field("out_red", out_red_o, want.vtx.r);
        check_field("out_green", out_green_o, want.vtx.g);
        check_field("out_blue", out_blue_o, want.vtx.b);
        check_field("out_alpha", out_alpha_o, want.vtx.a);
        check_field("raster_mode", WORD_W'(raster_mode_o), WORD_W'(want.raster_mode));
        check_field("batch_count", WORD_W'(batch_count_o), WORD_W'(want.batch_count));
        check_field("last", WORD_W'(last_o), WORD_W'(want.last));
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic test_passthrough_and_ignored();
    // Right after reset the block is in points mode, so this passes through.
    send_request(ACT_VERTEX, MODE_QUADS, vertex_t'('1));
    send_request(ACT_UNUSED, MODE_FAN, random_vertex());
    send_request(ACT_END, MODE_POINTS, vertex_t'('0));
  endtask

  task automatic test_quad_expansion();
    send_request(ACT_BEGIN, MODE_QUADS, random_vertex());
    send_request(ACT_VERTEX, MODE_POINTS, vertex_t'('0));
    send_request(ACT_VERTEX, MODE_POINTS, vertex_t'({7{32'hAAAA_AAAA}}));
    send_request(ACT_VERTEX, MODE_POINTS, vertex_t'({7{32'h5555_5555}}));
    send_request(ACT_VERTEX, MODE_POINTS, vertex_t'('1));
    // A partial quad is flushed by the end request.
    send_request(ACT_VERTEX, MODE_POINTS, random_vertex());
    send_request(ACT_END, MODE_QUADS, random_vertex());
  endtask

  task automatic test_fan_expansion();
    send_request(ACT_BEGIN, MODE_FAN, random_vertex());
    repeat (4) send_request(ACT_VERTEX, MODE_FAN, random_vertex());
    send_request(ACT_END, MODE_FAN, random_vertex());
  endtask

  task automatic test_mid_batch_begin_and_empty();
    send_request(ACT_BEGIN, MODE_TRIS, random_vertex());
    repeat (2) send_request(ACT_VERTEX, MODE_TRIS, random_vertex());
    // The held triangle corners are dropped, but the batch total is kept.
    send_request(ACT_BEGIN, MODE_LINES, random_vertex());
    send_request(ACT_VERTEX, MODE_LOOP, random_vertex());
    send_request(ACT_END, MODE_STRIP, random_vertex());
    send_request(ACT_BEGIN, MODE_TRISTRIP, random_vertex());
    send_request(ACT_END, MODE_TRISTRIP, random_vertex());
  endtask

  task automatic test_random_batches(input int unsigned n_items, input int sidle,
                                     input int rstall);
    int unsigned         sent;
    int unsigned         n_vtx;
    logic [ACTION_W-1:0] act;
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        // Stray request of any kind, including the unused code.
        act = ACTION_W'($urandom_range(3));
        send_request(act, MODE_W'($urandom_range(7)), random_vertex());
        if (act != ACT_UNUSED) sent++;
      end else begin
        send_request(ACT_BEGIN, MODE_W'($urandom_range(7)), random_vertex());
        n_vtx = $urandom_range(9);
        repeat (n_vtx) send_request(ACT_VERTEX, MODE_W'($urandom_range(7)), random_vertex());
        send_request(ACT_END, MODE_W'($urandom_range(7)), random_vertex());
        sent += n_vtx + 2;
      end
    end
    // Hold off until the block has delivered everything.
    drain_results();
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    action_i    <= ACT_VERTEX;
    prim_mode_i <= MODE_POINTS;
    pos_x_i     <= '0;
    pos_y_i     <= '0;
    pos_z_i     <= '0;
    red_i       <= '0;
    green_i     <= '0;
    blue_i      <= '0;
    alpha_i     <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_passthrough_and_ignored();
    test_quad_expansion();
    test_fan_expansion();
    test_mid_batch_begin_and_empty();
    test_random_batches(100, 29, 74);
    test_random_batches(100, 74, 29);
    test_random_batches(100, 0, 0);

    drain_results();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/pqf_pkg.sv
hw/rtl/pqf_front.sv
hw/rtl/pqf_queue.sv
hw/rtl/pqf_back.sv
hw/rtl/primitive_assembler_quad_fan.sv
tb/sv/testbench.sv
